// ----- rtl/gdn_pkg.sv -----
// shared types, constants and small tables for the gregorian day number converter
// no dependencies
package gdn_pkg;

  localparam int NumStages = 14;

  localparam logic CMD_TO_NUMBER = 1'b0;
  localparam logic CMD_TO_DATE   = 1'b1;

  localparam logic REG_MIN_YEAR = 1'b0;
  localparam logic REG_MAX_YEAR = 1'b1;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_YEAR  = 2'd1;
  localparam logic [1:0] ERR_MONTH = 2'd2;
  localparam logic [1:0] ERR_DAY   = 2'd3;

  localparam logic [13:0] MIN_YEAR_RST   = 14'd1858;
  localparam logic [13:0] MAX_YEAR_RST   = 14'd2558;
  localparam logic [23:0] DAY_NUMBER_MAX = 24'd4194303;

  // date record carried down the whole pipe
  typedef struct packed {
    logic               cmd;
    logic [1:0]         err;
    logic [23:0]        jdn;
    logic signed [14:0] y;
    logic [3:0]         m;
    logic [4:0]         d;
    logic [14:0]        tv;   // year + 4800, never negative
  } rec_t;

  // working values of both conversion directions
  typedef struct packed {
    logic [14:0] y1;
    logic [14:0] yc;
    logic [8:0]  b;
    logic [24:0] a1;
    logic [7:0]  cq;
    logic [22:0] s;
    logic [6:0]  n;
    logic [21:0] r;
    logic [15:0] s2;
    logic [6:0]  i;
    logic [8:0]  s3;
    logic [3:0]  q;
    logic [7:0]  tq;
    logic [2:0]  wd;
    logic [22:0] mjd;
  } wk_t;

  // days before the month, counted from march: floor(367 k / 12) = floor(2447 k / 80)
  function automatic logic [8:0] month_offset(input logic [3:0] k);
    logic [8:0] v;
    case (k)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd30;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd91;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd152;
      4'd6:    v = 9'd183;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd244;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd305;
      4'd11:   v = 9'd336;
      4'd12:   v = 9'd367;
      4'd13:   v = 9'd397;
      4'd14:   v = 9'd428;
      default: v = 9'd458;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/gregorian_day_number_converter_unit.sv -----
// gregorian date <-> julian day number converter, fourteen-stage pipeline
// depends on gdn_pkg
//
//   channel  | signals                                      | direction
//   ---------+----------------------------------------------+----------
//   request  | in_valid/in_ready, cmd, year_in, month_in,   | in
//            | day_in, day_number_in                        |
//   result   | out_valid/out_ready, day_number, ...,        | out
//            | range_error                                  |
//   config   | cfg_we, cfg_index, cfg_data                  | in
//
// one word enters per cycle while in_ready is high; the depth of the pipe is
// set by the chain of constant-divisor steps of the day number to date direction.
// every stage holds its word while the stage after it is full and stalled,
// so input is taken whenever some stage ahead has room.
// reset empties the pipe and restores the year limits to 1858 and 2558.
module gregorian_day_number_converter_unit
  import gdn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [13:0]        year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic [21:0]        day_number_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [21:0]        day_number,
  output logic signed [22:0] mod_day_number,
  output logic signed [14:0] year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  output logic [2:0]         weekday,
  output logic               leap_year,
  output logic [4:0]         month_days,
  output logic [1:0]         range_error,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [13:0]        cfg_data
);

  logic [13:0] min_year;
  logic [13:0] max_year;

  logic [NumStages:1] vld;
  logic [NumStages:1] en;

  rec_t rc      [1:NumStages-1];
  rec_t rc_next [1:NumStages-1];
  wk_t  wk      [1:NumStages-1];
  wk_t  wk_next [1:NumStages-1];

  logic        early;
  logic [26:0] prod_c;
  logic [32:0] prod_n;
  logic [9:0]  cq3;
  logic [24:0] jdn_sum;
  logic [24:0] rem3;
  logic        ge4;
  logic [18:0] fix4;
  logic [15:0] u5;
  logic [35:0] prod_i;
  logic [15:0] u6;
  logic [27:0] rem6;
  logic [17:0] s3w;
  logic [18:0] prod_q;
  logic [14:0] rem10;
  logic        t12;
  logic [8:0]  e12;
  logic [14:0] tv12;
  logic [26:0] prod_t;
  logic [5:0]  osum;
  logic [3:0]  fold;
  logic [2:0]  wdr;
  logic [14:0] tr14;
  logic        leap14;
  logic [4:0]  mlen14;
  logic [1:0]  err14;

  // year limits
  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= MIN_YEAR_RST;
      max_year <= MAX_YEAR_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_MIN_YEAR) begin
        min_year <= cfg_data;
      end
      if (cfg_index == REG_MAX_YEAR) begin
        max_year <= cfg_data;
      end
    end
  end

  // stage enables
  always_comb begin
    en[NumStages] = !vld[NumStages] || out_ready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[NumStages];

  always_comb begin
    // stage 1: checks, date offsets, day number bias
    rc_next[1]      = '0;
    wk_next[1]      = '0;
    early           = month_in <= 4'd2;
    rc_next[1].cmd  = cmd;
    rc_next[1].jdn  = 24'(day_number_in);
    rc_next[1].y    = $signed({1'b0, year_in});
    rc_next[1].m    = month_in;
    rc_next[1].d    = day_in;
    rc_next[1].tv   = 15'(year_in) + 15'd4800;
    rc_next[1].err  = ERR_NONE;
    if (cmd == CMD_TO_NUMBER) begin
      if (year_in < min_year || year_in > max_year) begin
        rc_next[1].err = ERR_YEAR;
      end else if (!(month_in inside {[4'd1:4'd12]})) begin
        rc_next[1].err = ERR_MONTH;
      end
    end
    wk_next[1].y1 = 15'(year_in) + 15'd4800 - 15'(early);
    wk_next[1].yc = 15'(year_in) + 15'd4900 - 15'(early);
    wk_next[1].b  = month_offset(early ? month_in + 4'd10 : month_in - 4'd2);
    wk_next[1].s  = 23'(day_number_in) + 23'd68569;

    // stage 2: year products, century estimate, era estimate
    rc_next[2]    = rc[1];
    wk_next[2]    = wk[1];
    wk_next[2].a1 = 25'(wk[1].y1) * 25'd1461;
    prod_c        = 27'(wk[1].yc) * 27'd5243;
    wk_next[2].cq = prod_c[26:19];
    prod_n        = 33'({wk[1].s, 2'b00}) * 33'd229;
    wk_next[2].n  = prod_n[31:25];

    // stage 3: date day number, era remainder
    rc_next[3] = rc[2];
    wk_next[3] = wk[2];
    cq3        = 10'(wk[2].cq) * 10'd3;
    jdn_sum    = 25'(wk[2].a1[24:2]) + 25'(wk[2].b) + 25'(rc[2].d)
               - 25'(cq3[9:2]) - 25'd32075;
    if (rc[2].cmd == CMD_TO_NUMBER) begin
      rc_next[3].jdn = jdn_sum[23:0];
    end
    rem3         = 25'({wk[2].s, 2'b00}) - 25'(wk[2].n) * 25'd146097;
    wk_next[3].r = 22'(rem3[18:0]);

    // stage 4: era correction
    rc_next[4]    = rc[3];
    wk_next[4]    = wk[3];
    ge4           = wk[3].r[18:0] >= 19'd146097;
    fix4          = ge4 ? wk[3].r[18:0] - 19'd146097 : wk[3].r[18:0];
    wk_next[4].n  = wk[3].n + 7'(ge4);
    wk_next[4].s2 = fix4[17:2];

    // stage 5: year of era estimate
    rc_next[5]   = rc[4];
    wk_next[5]   = wk[4];
    u5           = wk[4].s2 + 16'd1;
    prod_i       = 36'(u5) * 36'd732000;
    wk_next[5].i = prod_i[34:28];

    // stage 6: year of era remainder
    rc_next[6]   = rc[5];
    wk_next[6]   = wk[5];
    u6           = wk[5].s2 + 16'd1;
    rem6         = 28'(u6) * 28'd4000 - 28'(wk[5].i) * 28'd1461001;
    wk_next[6].r = rem6[21:0];

    // stage 7: year of era correction
    rc_next[7]   = rc[6];
    wk_next[7]   = wk[6];
    wk_next[7].i = wk[6].i + 7'(wk[6].r >= 22'd1461001);

    // stage 8: day of year from march
    rc_next[8]    = rc[7];
    wk_next[8]    = wk[7];
    s3w           = 18'(wk[7].s2) + 18'd31 - ((18'(wk[7].i) * 18'd1461) >> 2);
    wk_next[8].s3 = s3w[8:0];

    // stage 9: month estimate
    rc_next[9]   = rc[8];
    wk_next[9]   = wk[8];
    prod_q       = 19'(wk[8].s3) * 19'd1040;
    wk_next[9].q = prod_q[18:15];

    // stage 10: month remainder
    rc_next[10]   = rc[9];
    wk_next[10]   = wk[9];
    rem10         = 15'(wk[9].s3) * 15'd80 - 15'(wk[9].q) * 15'd2447;
    wk_next[10].r = 22'(rem10[12:0]);

    // stage 11: month correction
    rc_next[11]   = rc[10];
    wk_next[11]   = wk[10];
    wk_next[11].q = wk[10].q + 4'(wk[10].r[12:0] >= 13'd2447);

    // stage 12: assemble the date
    rc_next[12] = rc[11];
    wk_next[12] = wk[11];
    t12         = wk[11].q >= 4'd11;
    e12         = wk[11].s3 - month_offset(wk[11].q);
    tv12        = 15'(wk[11].n) * 15'd100 + 15'(wk[11].i) + 15'(t12) - 15'd100;
    if (rc[11].cmd == CMD_TO_DATE) begin
      rc_next[12].d  = e12[4:0];
      rc_next[12].m  = t12 ? wk[11].q - 4'd10 : wk[11].q + 4'd2;
      rc_next[12].tv = tv12;
      rc_next[12].y  = $signed(tv12) - 15'sd4800;
    end

    // stage 13: century of the year, weekday, modified day number
    rc_next[13]    = rc[12];
    wk_next[13]    = wk[12];
    prod_t         = 27'(rc[12].tv) * 27'd5243;
    wk_next[13].tq = prod_t[26:19];
    osum = '0;
    for (int g = 0; g < 8; g++) begin
      osum = osum + 6'(rc[12].jdn[3*g +: 3]);
    end
    fold            = 4'(osum[5:3]) + 4'(osum[2:0]);
    wdr             = (fold >= 4'd7) ? 3'(fold - 4'd7) : fold[2:0];
    wk_next[13].wd  = wdr + 3'd1;
    wk_next[13].mjd = $signed({1'b0, rc[12].jdn[21:0]}) - 23'sd2400001;

    // final: leap rule, month length, remaining checks
    tr14   = rc[13].tv - 15'(wk[13].tq) * 15'd100;
    leap14 = (rc[13].tv[1:0] == 2'd0) && ((tr14 != 15'd0) || (wk[13].tq[1:0] == 2'd0));
    mlen14 = month_len(leap14, rc[13].m);
    err14  = rc[13].err;
    if (rc[13].cmd == CMD_TO_NUMBER && rc[13].err == ERR_NONE) begin
      if (rc[13].d == 5'd0 || rc[13].d > mlen14) begin
        err14 = ERR_DAY;
      end else if (rc[13].jdn > DAY_NUMBER_MAX) begin
        err14 = ERR_YEAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        rc[k] <= rc_next[k];
        wk[k] <= wk_next[k];
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (en[NumStages]) begin
      range_error <= err14;
      if (err14 != ERR_NONE) begin
        day_number     <= '0;
        mod_day_number <= '0;
        year_out       <= '0;
        month_out      <= '0;
        day_out        <= '0;
        weekday        <= '0;
        leap_year      <= 1'b0;
        month_days     <= '0;
      end else begin
        day_number     <= rc[13].jdn[21:0];
        mod_day_number <= $signed(wk[13].mjd);
        year_out       <= rc[13].y;
        month_out      <= rc[13].m;
        day_out        <= rc[13].d;
        weekday        <= wk[13].wd;
        leap_year      <= leap14;
        month_days     <= mlen14;
      end
    end
  end

  // a drained output never blocks the input
  assert property (@(posedge clk) disable iff (rst) out_ready |-> in_ready)
    else $error("input blocked while output drains");

  // error words carry nothing but the code
  assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error != ERR_NONE |->
      day_number == '0 && weekday == '0 && month_days == '0 && day_out == '0)
    else $error("error word with payload");

  // good words carry a real weekday and month length
  assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error == ERR_NONE |->
      weekday != 3'd0 && month_days >= 5'd28 && month_out != 4'd0 && day_out != 5'd0)
    else $error("good word out of range");

  // february length follows the leap flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error == ERR_NONE && month_out == 4'd2 |->
      month_days == (leap_year ? 5'd29 : 5'd28))
    else $error("february length disagrees with leap flag");

endmodule

// ----- bench/gregorian_day_number_converter_checker.sv -----
// result checker for the gregorian day number converter: watches the request, result and
// config ports, predicts each result word and compares it field by field
// depends on gdn_pkg
module gregorian_day_number_converter_checker
  import gdn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               cmd,
  input  logic [13:0]        year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic [21:0]        day_number_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [21:0]        day_number,
  input  logic signed [22:0] mod_day_number,
  input  logic signed [14:0] year_out,
  input  logic [3:0]         month_out,
  input  logic [4:0]         day_out,
  input  logic [2:0]         weekday,
  input  logic               leap_year,
  input  logic [4:0]         month_days,
  input  logic [1:0]         range_error,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [13:0]        cfg_data,
  output int                 failures,
  output int                 pending,
  output int                 compared
);

  localparam longint JdnLimit = 4194303;
  localparam longint MjdBias  = 2400001;
  localparam int     PrintCap = 60;

  typedef struct packed {
    logic [21:0]        day_number;
    logic signed [22:0] mod_day_number;
    logic signed [14:0] year_out;
    logic [3:0]         month_out;
    logic [4:0]         day_out;
    logic [2:0]         weekday;
    logic               leap_year;
    logic [4:0]         month_days;
    logic [1:0]         range_error;
  } date_word_t;

  date_word_t  awaited_words[$];
  logic [13:0] lo_year = MIN_YEAR_RST;
  logic [13:0] hi_year = MAX_YEAR_RST;
  int          fail_count = 0;
  int          awaited_count = 0;
  int          compared_count = 0;

  assign failures = fail_count;
  assign pending  = awaited_count;
  assign compared = compared_count;

  function automatic logic leap_of_year(longint y);
    longint t;
    t = y + 4800;
    if (t < 0) t = 0;
    return (t % 4 == 0) && ((t % 100 != 0) || (t % 400 == 0));
  endfunction

  function automatic logic [4:0] month_length_of(longint y, longint m);
    if (m == 2) return leap_of_year(y) ? 5'd29 : 5'd28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 5'd30;
    return 5'd31;
  endfunction

  function automatic date_word_t fill_word(longint jdn, longint y, longint m, longint d);
    date_word_t w;
    longint     mjd;
    longint     wd;
    mjd = jdn - MjdBias;
    wd  = jdn % 7 + 1;
    w.day_number     = jdn[21:0];
    w.mod_day_number = mjd[22:0];
    w.year_out       = y[14:0];
    w.month_out      = m[3:0];
    w.day_out        = d[4:0];
    w.weekday        = wd[2:0];
    w.leap_year      = leap_of_year(y);
    w.month_days     = month_length_of(y, m);
    w.range_error    = ERR_NONE;
    return w;
  endfunction

  function automatic date_word_t convert_word(logic c, logic [13:0] yi, logic [3:0] mi,
                                              logic [4:0] di, logic [21:0] pi,
                                              logic [13:0] lo, logic [13:0] hi);
    date_word_t w;
    longint     y, m, d, a, jdn, s, n, i, q, e, t;
    w = '0;
    if (c == CMD_TO_NUMBER) begin
      y = longint'(yi);
      m = longint'(mi);
      d = longint'(di);
      if (y < longint'(lo) || y > longint'(hi)) begin
        w.range_error = ERR_YEAR;
      end else if (m < 1 || m > 12) begin
        w.range_error = ERR_MONTH;
      end else if (d < 1 || d > longint'(month_length_of(y, m))) begin
        w.range_error = ERR_DAY;
      end else begin
        // january and february count as months 13 and 14 of the year before
        a = (m <= 2) ? -1 : 0;
        jdn = (1461 * (y + 4800 + a)) / 4 + (367 * (m - 2 - 12 * a)) / 12
            - (3 * ((y + 4900 + a) / 100)) / 4 + d - 32075;
        if (jdn < 0 || jdn > JdnLimit) w.range_error = ERR_YEAR;
        else w = fill_word(jdn, y, m, d);
      end
    end else begin
      s = longint'(pi) + 68569;
      n = (4 * s) / 146097;
      s = s - (146097 * n + 3) / 4;
      i = (4000 * (s + 1)) / 1461001;
      s = s - (1461 * i) / 4 + 31;
      q = (80 * s) / 2447;
      e = s - (2447 * q) / 80;
      t = q / 11;
      m = q + 2 - 12 * t;
      y = 100 * (n - 49) + i + t;
      w = fill_word(longint'(pi), y, m, e);
    end
    return w;
  endfunction

  task automatic report(string msg);
    fail_count++;
    if (fail_count <= PrintCap) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // sampled mid-cycle: what holds here is what the next rising edge sees
  always @(negedge clk) begin
    date_word_t want;
    if (rst) begin
      awaited_words.delete();
      lo_year = MIN_YEAR_RST;
      hi_year = MAX_YEAR_RST;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          report($sformatf("result word with no request waiting, day_number %0d", day_number));
        end else begin
          want = awaited_words.pop_front();
          check_field("day_number", longint'(day_number), longint'(want.day_number));
          check_field("mod_day_number", longint'(mod_day_number),
                      longint'(want.mod_day_number));
          check_field("year_out", longint'(year_out), longint'(want.year_out));
          check_field("month_out", longint'(month_out), longint'(want.month_out));
          check_field("day_out", longint'(day_out), longint'(want.day_out));
          check_field("weekday", longint'(weekday), longint'(want.weekday));
          check_field("leap_year", longint'(leap_year), longint'(want.leap_year));
          check_field("month_days", longint'(month_days), longint'(want.month_days));
          check_field("range_error", longint'(range_error), longint'(want.range_error));
          compared_count++;
        end
      end
      if (in_valid && in_ready)
        awaited_words.push_back(convert_word(cmd, year_in, month_in, day_in, day_number_in,
                                             lo_year, hi_year));
      if (cfg_we) begin
        if (cfg_index == REG_MIN_YEAR) lo_year = cfg_data;
        else hi_year = cfg_data;
      end
    end
    awaited_count = awaited_words.size();
  end

endmodule

// ----- bench/gregorian_day_number_converter_unit_test.sv -----
// testbench top for the gregorian day number converter: directed and random request words
// under several year limits, random idling on both channels; verdict from the checker
// depends on gdn_pkg, gregorian_day_number_converter_unit, gregorian_day_number_converter_checker
module gregorian_day_number_converter_unit_test;
  import gdn_pkg::*;

  localparam int CycleLimit = 100000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = CMD_TO_NUMBER;
  logic [13:0]        year_in = '0;
  logic [3:0]         month_in = '0;
  logic [4:0]         day_in = '0;
  logic [21:0]        day_number_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [21:0]        day_number;
  logic signed [22:0] mod_day_number;
  logic signed [14:0] year_out;
  logic [3:0]         month_out;
  logic [4:0]         day_out;
  logic [2:0]         weekday;
  logic               leap_year;
  logic [4:0]         month_days;
  logic [1:0]         range_error;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_MIN_YEAR;
  logic [13:0]        cfg_data = '0;

  int fail_total;
  int awaiting;
  int checked;
  int cycle_count = 0;
  int date_words = 0;
  int number_words = 0;
  int limit_settings = 1;
  bit steady = 1'b0;

  gregorian_day_number_converter_unit dut (.*);

  gregorian_day_number_converter_checker checker_i (
    .failures(fail_total),
    .pending(awaiting),
    .compared(checked),
    .*
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 37);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_word(logic c, logic [13:0] y, logic [3:0] m, logic [4:0] d,
                           logic [21:0] p);
    while (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= c;
    year_in       <= y;
    month_in      <= m;
    day_in        <= d;
    day_number_in <= p;
    if (c == CMD_TO_NUMBER) date_words++;
    else number_words++;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic send_date(int y, int m, int d);
    send_word(CMD_TO_NUMBER, 14'(y), 4'(m), 5'(d), 22'($urandom_range(4194303)));
  endtask

  task automatic send_number(int p);
    send_word(CMD_TO_DATE, 14'($urandom_range(9999)), 4'($urandom_range(15)),
              5'($urandom_range(31)), 22'(p));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaiting != 0) @(posedge clk);
    repeat (NumStages + 4) @(posedge clk);
  endtask

  task automatic set_limits(logic [13:0] lo, logic [13:0] hi);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_YEAR;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_MAX_YEAR;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_settings++;
  endtask

  task automatic run_phase(int count, logic [13:0] lo, logic [13:0] hi, bit quiet_start);
    int roll;
    set_limits(lo, hi);
    for (int k = 0; k < count; k++) begin
      steady <= quiet_start && k < 150;
      roll = $urandom_range(99);
      if (roll < 45) begin
        // date within the limits unless they are crossed, month in range, days 29 to 31 now and then
        send_date(lo <= hi ? $urandom_range(hi, lo) : $urandom_range(9999),
                  $urandom_range(12, 1),
                  $urandom_range(3) == 0 ? $urandom_range(31, 29) : $urandom_range(28, 1));
      end else if (roll < 60) begin
        send_date($urandom_range(9999), $urandom_range(15), $urandom_range(31));
      end else if (roll < 80) begin
        send_number($urandom_range(4194303));
      end else if (roll < 90) begin
        send_number($urandom_range(2600000, 2299160));
      end else if (roll < 95) begin
        send_number($urandom_range(2000));
      end else begin
        send_number($urandom_range(4194303, 4192303));
      end
    end
    steady <= 1'b0;
  endtask

  initial begin
    int lo;
    int hi;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset limits
    send_date(1858, 11, 17);
    send_date(2000, 2, 29);
    send_date(1900, 2, 29);
    send_date(1900, 2, 28);
    send_date(1857, 12, 31);
    send_date(2559, 1, 1);
    send_date(2558, 12, 31);
    send_date(1858, 1, 1);
    send_date(2020, 0, 15);
    send_date(2020, 13, 1);
    send_date(2020, 15, 31);
    send_date(2021, 4, 31);
    send_date(2021, 6, 0);
    send_date(9999, 15, 0);
    send_number(0);
    send_number(4194303);
    send_number(2400001);
    send_number(2451545);
    send_number(2299160);
    send_number(1721425);

    // widest limits: year zero and dates past the widest day number
    set_limits(14'd0, 14'd9999);
    send_date(0, 1, 1);
    send_date(9999, 12, 31);
    send_date(2400, 2, 29);
    send_date(2100, 2, 29);

    // crossed limits reject every date
    set_limits(14'd5000, 14'd100);
    send_date(2000, 6, 15);
    send_date(100, 1, 1);

    run_phase(300, 14'd0, 14'd9999, 1'b0);
    run_phase(300, 14'd1583, 14'd2100, 1'b1);
    lo = $urandom_range(9999);
    hi = $urandom_range(9999);
    run_phase(250, 14'(lo), 14'(hi), 1'b0);
    lo = $urandom_range(2600, 1600);
    run_phase(200, 14'(lo), 14'(lo), 1'b0);
    run_phase(350, MIN_YEAR_RST, MAX_YEAR_RST, 1'b0);
    wait_for_results();

    $display("covered %0d date words and %0d day number words under %0d year-limit settings",
             date_words, number_words, limit_settings);
    $display("%0d result words compared, %0d mismatches", checked, fail_total);
    if (fail_total == 0 && awaiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
